// ===== rtl/core/fpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared widths, reset values and controller command type for the FIFO page
// replacement core.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int PAGE_W  = 8;   // width of page ports
  localparam int SLOT_W  = 3;   // width of slot port
  localparam int CAP_W   = 4;   // width of frame_capacity register
  localparam int TOTAL_W = 32;  // width of fault total

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the page of an accepted transaction
    logic update;   // look up, update frames and load result registers
  } cmd_t;

endpackage

// ===== rtl/core/fpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ctrl
// Two-state controller: takes a transaction, then runs a lookup state and
// strobes the result.
// ----------------------------------------------------------------------------
module fpr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output fpr_pkg::cmd_t cmd
);

  typedef enum logic [0:0] {
    IDLE,
    LOOKUP
  } state_t;

  state_t state;

  always_comb begin
    cmd.capture = start && !busy;
    cmd.update  = (state == LOOKUP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= LOOKUP;
            busy  <= 1'b1;
          end
        end
        LOOKUP: begin
          state <= IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fpr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_datapath
// Frame table, fill count, rotating oldest pointer, fault counter and the
// result registers.
// ----------------------------------------------------------------------------
module fpr_datapath #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fpr_pkg::cmd_t                cmd,
  input  logic                         cfg_we,
  input  logic [fpr_pkg::CAP_W-1:0]    cfg_data,
  input  logic [fpr_pkg::PAGE_W-1:0]   page,
  output logic                         hit,
  output logic                         counted_fault,
  output logic [fpr_pkg::SLOT_W-1:0]   slot,
  output logic                         evicted_valid,
  output logic [fpr_pkg::PAGE_W-1:0]   evicted_page,
  output logic [fpr_pkg::TOTAL_W-1:0]  fault_total
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > fpr_pkg::CAP_W) ? CNT_W : fpr_pkg::CAP_W;

  logic [PAGE_BITS-1:0]          frame_pages [FRAMES];
  logic [CNT_W-1:0]              filled_count;
  logic [IDX_W-1:0]              oldest_slot;
  logic [fpr_pkg::TOTAL_W-1:0]   fault_counter;
  logic [fpr_pkg::CAP_W-1:0]     frame_capacity;
  logic [PAGE_BITS-1:0]          page_reg;

  logic [CMP_W-1:0]     cap_wide;
  logic [CNT_W-1:0]     cap_used;
  logic                 found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 fill;
  logic [IDX_W-1:0]     repl_idx;
  logic [CNT_W-1:0]     repl_next;

  // clamp capacity to 1..FRAMES
  always_comb begin
    cap_wide = CMP_W'(frame_capacity);
    if (cap_wide == '0) begin
      cap_wide = CMP_W'(1);
    end else if (cap_wide > CMP_W'(FRAMES)) begin
      cap_wide = CMP_W'(FRAMES);
    end
    cap_used = cap_wide[CNT_W-1:0];
  end

  // lowest matching resident slot
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!found && (CNT_W'(i) < filled_count) && (frame_pages[i] == page_reg)) begin
        found   = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // replacement slot and the pointer after it
  always_comb begin
    fill     = (filled_count < cap_used);
    repl_idx = oldest_slot;
    if (CNT_W'(oldest_slot) >= filled_count) begin
      repl_idx = '0;
    end
    repl_next = CNT_W'(repl_idx) + CNT_W'(1);
    if (repl_next >= filled_count) begin
      repl_next = '0;
    end
  end

  assign fault_total = fault_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_pages[i] <= '0;
      end
      filled_count   <= '0;
      oldest_slot    <= '0;
      fault_counter  <= '0;
      frame_capacity <= fpr_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        frame_capacity <= cfg_data;
      end
      if (cmd.update && !found) begin
        if (fill) begin
          frame_pages[filled_count[IDX_W-1:0]] <= page_reg;
          filled_count <= filled_count + CNT_W'(1);
        end else begin
          frame_pages[repl_idx] <= page_reg;
          oldest_slot <= repl_next[IDX_W-1:0];
          if (fault_counter != '1) begin
            fault_counter <= fault_counter + fpr_pkg::TOTAL_W'(1);
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_reg <= PAGE_BITS'(page);
    end
    if (cmd.update) begin
      hit <= found;
      priority if (found) begin
        counted_fault <= 1'b0;
        slot          <= fpr_pkg::SLOT_W'(hit_idx);
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
      end else if (fill) begin
        counted_fault <= 1'b0;
        slot          <= fpr_pkg::SLOT_W'(filled_count[IDX_W-1:0]);
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
      end else begin
        counted_fault <= 1'b1;
        slot          <= fpr_pkg::SLOT_W'(repl_idx);
        evicted_valid <= 1'b1;
        evicted_page  <= fpr_pkg::PAGE_W'(frame_pages[repl_idx]);
      end
    end
  end

endmodule

// ===== rtl/core/fifo_page_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_core
// FIFO page replacement over a table of resident frames, one page reference
// per transaction, one result per reference.
// ----------------------------------------------------------------------------
// result strobe (done) is registered at the end of the LOOKUP state that
//   follows the accepting edge; no transaction is taken while busy, but a new
//   one is taken while done is shown
// the receiver cannot stall: each result is valid for exactly one cycle
// reset (synchronous, active high) clears all frames, the fill count, the
//   oldest pointer and the fault total, and sets frame_capacity to 3
module fifo_page_replacement_core #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [fpr_pkg::CAP_W-1:0]    cfg_data,
  input  logic [fpr_pkg::PAGE_W-1:0]   page,
  output logic                         done,
  output logic                         hit,
  output logic                         counted_fault,
  output logic [fpr_pkg::SLOT_W-1:0]   slot,
  output logic                         evicted_valid,
  output logic [fpr_pkg::PAGE_W-1:0]   evicted_page,
  output logic [fpr_pkg::TOTAL_W-1:0]  fault_total
);

  fpr_pkg::cmd_t cmd;

  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .page          (page),
    .hit           (hit),
    .counted_fault (counted_fault),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

`ifndef SYNTH
  // every accepted transaction yields a done strobe after its LOOKUP state
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  // busy is always cleared in the cycle after it is set
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // a hit never faults or evicts
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!counted_fault && !evicted_valid && (evicted_page == '0)))
    else $error("hit reported with fault or eviction");

  // a counted fault always evicts and advances the total unless saturated
  a_fault_evicts: assert property (@(posedge clk) disable iff (rst)
    (done && counted_fault) |-> (evicted_valid && !hit && (fault_total != '0)))
    else $error("fault without eviction or total");
`endif

endmodule
